@@ hw/rtl/fte_pkg.sv @@
package fte_pkg;

    localparam int TABLE_WORDS = 1042;
    localparam int ROUNDS      = 16;
    localparam int P_WORDS     = ROUNDS + 2;
    localparam int SBOX_WORDS  = TABLE_WORDS - P_WORDS;

    localparam int TIDX_W  = $clog2(TABLE_WORDS);
    localparam int PIDX_W  = $clog2(P_WORDS);
    localparam int SBOX_AW = $clog2(SBOX_WORDS);
    localparam int RND_W   = $clog2(ROUNDS);

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ENC   = 2'd1,
        REQ_DEC   = 2'd2,
        REQ_SCHED = 2'd3
    } req_t;

    // S-box select, upper bits of the S-box memory address
    typedef enum logic [1:0] {
        SBOX_0 = 2'd0,
        SBOX_1 = 2'd1,
        SBOX_2 = 2'd2,
        SBOX_3 = 2'd3
    } sbox_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CI_INIT,
        ST_CI_RND,
        ST_CI_FIN,
        ST_KC1_SET,
        ST_KC1_WB,
        ST_KC0_SET,
        ST_KC0_WB,
        ST_KEY_XOR,
        ST_FILL_SET,
        ST_FILL_WH,
        ST_FILL_WL,
        ST_SK_NEXT,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        JOB_USER,
        JOB_KC1,
        JOB_KC0,
        JOB_FILL
    } job_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD_WORD,
        DP_CI_INIT,
        DP_CI_RD0,
        DP_CI_RD1,
        DP_CI_RD2,
        DP_CI_RD3,
        DP_CI_FIN,
        DP_KC1_SET,
        DP_KC1_WB,
        DP_KC0_SET,
        DP_KC0_WB,
        DP_KEY_XOR,
        DP_FILL_SET,
        DP_FILL_WH,
        DP_FILL_WL,
        DP_KC_SHIFT,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                chain;
        logic                dec;
        logic                zero_res;
        logic [PIDX_W-1:0]   p_idx;
        logic [TIDX_W-1:0]   cnt;
        logic [1:0]          kc_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/fte_ctrl.sv @@
module fte_ctrl
    import fte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] req_type,
    input  logic [1:0] sched_level,
    input  logic [1:0] key_modulus,
    output logic       in_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t         state_reg, state_next;
    job_t                job_reg, job_next;
    req_t                req_reg, req_next;
    logic                dec_reg, dec_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          level_reg, level_next;
    logic [1:0]          mod_reg, mod_next;
    logic [1:0]          app_reg, app_next;
    logic [TIDX_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]          kc_sel_reg, kc_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            job_reg    <= JOB_USER;
            req_reg    <= REQ_LOAD;
            dec_reg    <= 1'b0;
            rnd_reg    <= '0;
            phase_reg  <= '0;
            level_reg  <= '0;
            mod_reg    <= 2'd1;
            app_reg    <= '0;
            cnt_reg    <= '0;
            kc_sel_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            job_reg    <= job_next;
            req_reg    <= req_next;
            dec_reg    <= dec_next;
            rnd_reg    <= rnd_next;
            phase_reg  <= phase_next;
            level_reg  <= level_next;
            mod_reg    <= mod_next;
            app_reg    <= app_next;
            cnt_reg    <= cnt_next;
            kc_sel_reg <= kc_sel_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        req_next    = req_reg;
        dec_next    = dec_reg;
        rnd_next    = rnd_reg;
        phase_next  = phase_reg;
        level_next  = level_reg;
        mod_next    = mod_reg;
        app_next    = app_reg;
        cnt_next    = cnt_reg;
        kc_sel_next = kc_sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_t'(req_type);
                    level_next = sched_level;
                    mod_next   = (key_modulus == 2'd0) ? 2'd1 : key_modulus;
                    app_next   = '0;
                    job_next   = JOB_USER;
                    dec_next   = (req_t'(req_type) == REQ_DEC);
                    unique case (req_t'(req_type))
                        REQ_LOAD:  state_next = ST_LOAD;
                        REQ_ENC,
                        REQ_DEC:   state_next = ST_CI_INIT;
                        REQ_SCHED: state_next = (sched_level == 2'd0) ? ST_DONE
                                                                      : ST_KC1_SET;
                    endcase
                end
            end
            ST_LOAD:
                state_next = ST_DONE;
            ST_CI_INIT:
            begin
                phase_next = '0;
                state_next = ST_CI_RND;
            end
            ST_CI_RND:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    if (rnd_reg == RND_W'(ROUNDS - 1))
                    begin
                        rnd_next   = '0;
                        state_next = ST_CI_FIN;
                    end
                    else
                        rnd_next = rnd_reg + RND_W'(1);
                end
            end
            ST_CI_FIN:
            begin
                unique case (job_reg)
                    JOB_USER: state_next = ST_DONE;
                    JOB_KC1:  state_next = ST_KC1_WB;
                    JOB_KC0:  state_next = ST_KC0_WB;
                    JOB_FILL: state_next = ST_FILL_WH;
                endcase
            end
            ST_KC1_SET:
            begin
                job_next   = JOB_KC1;
                dec_next   = 1'b0;
                state_next = ST_CI_INIT;
            end
            ST_KC1_WB:
                state_next = ST_KC0_SET;
            ST_KC0_SET:
            begin
                job_next   = JOB_KC0;
                state_next = ST_CI_INIT;
            end
            ST_KC0_WB:
            begin
                cnt_next    = '0;
                kc_sel_next = '0;
                state_next  = ST_KEY_XOR;
            end
            ST_KEY_XOR:
            begin
                kc_sel_next = (kc_sel_reg == mod_reg - 2'd1) ? 2'd0 : kc_sel_reg + 2'd1;
                if (cnt_reg == TIDX_W'(P_WORDS - 1))
                    state_next = ST_FILL_SET;
                else
                    cnt_next = cnt_reg + TIDX_W'(1);
            end
            ST_FILL_SET:
            begin
                cnt_next   = '0;
                job_next   = JOB_FILL;
                state_next = ST_CI_INIT;
            end
            ST_FILL_WH:
                state_next = ST_FILL_WL;
            ST_FILL_WL:
            begin
                if (cnt_reg == TIDX_W'(TABLE_WORDS - 2))
                    state_next = ST_SK_NEXT;
                else
                begin
                    cnt_next   = cnt_reg + TIDX_W'(2);
                    state_next = ST_CI_INIT;
                end
            end
            ST_SK_NEXT:
            begin
                app_next   = app_reg + 2'd1;
                state_next = (app_reg + 2'd1 == level_reg) ? ST_DONE : ST_KC1_SET;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.op       = DP_NOP;
        cmd.chain    = (rnd_reg != '0);
        cmd.dec      = dec_reg;
        cmd.zero_res = (req_reg == REQ_LOAD) || (req_reg == REQ_SCHED);
        cmd.p_idx    = dec_reg ? PIDX_W'(P_WORDS - 1) - PIDX_W'(rnd_reg)
                               : PIDX_W'(rnd_reg);
        cmd.cnt      = cnt_reg;
        cmd.kc_sel   = kc_sel_reg;
        in_stall     = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:     cmd.op = in_valid ? DP_CAPTURE : DP_NOP;
            ST_LOAD:     cmd.op = DP_LOAD_WORD;
            ST_CI_INIT:  cmd.op = DP_CI_INIT;
            ST_CI_RND:
            begin
                unique case (phase_reg)
                    2'd0: cmd.op = DP_CI_RD0;
                    2'd1: cmd.op = DP_CI_RD1;
                    2'd2: cmd.op = DP_CI_RD2;
                    2'd3: cmd.op = DP_CI_RD3;
                endcase
            end
            ST_CI_FIN:   cmd.op = DP_CI_FIN;
            ST_KC1_SET:  cmd.op = DP_KC1_SET;
            ST_KC1_WB:   cmd.op = DP_KC1_WB;
            ST_KC0_SET:  cmd.op = DP_KC0_SET;
            ST_KC0_WB:   cmd.op = DP_KC0_WB;
            ST_KEY_XOR:
            begin
                cmd.op    = DP_KEY_XOR;
                cmd.p_idx = cnt_reg[PIDX_W-1:0];
            end
            ST_FILL_SET: cmd.op = DP_FILL_SET;
            ST_FILL_WH:  cmd.op = DP_FILL_WH;
            ST_FILL_WL:  cmd.op = DP_FILL_WL;
            // keycode shift falls between the second and third application
            ST_SK_NEXT:  cmd.op = (app_reg == 2'd1) ? DP_KC_SHIFT : DP_NOP;
            ST_DONE:     cmd.op = status.out_free ? DP_RESULT : DP_NOP;
            default:     cmd.op = DP_NOP;
        endcase
    end

endmodule

@@ hw/rtl/fte_datapath.sv @@
module fte_datapath
    import fte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [10:0] table_index,
    input  logic [31:0] table_value,
    input  logic [31:0] block_low,
    input  logic [31:0] block_high,
    input  logic [31:0] id_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_low,
    output logic [31:0] result_high
);

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // round keys in flops, S-boxes in one memory
    logic [31:0]        p_reg [P_WORDS];
    logic [31:0]        sbox_mem [SBOX_WORDS];
    logic [31:0]        mem_q_reg;

    logic [31:0]        lo_reg, hi_reg;
    logic [31:0]        y_reg, z_reg, acc_reg;
    logic [31:0]        kc0_reg, kc1_reg, kc2_reg;
    logic [TIDX_W-1:0]  tidx_reg;
    logic [31:0]        tval_reg;
    logic [31:0]        res_low_reg, res_high_reg;
    logic               out_valid_reg;

    logic [31:0]        p_rd;
    logic [31:0]        x_new;
    logic [31:0]        z_calc;
    logic [31:0]        z_src;
    logic [SBOX_AW-1:0] rd_addr;
    logic [31:0]        kc_word;

    logic               t_we;
    logic [TIDX_W-1:0]  t_idx;
    logic [31:0]        t_data;
    logic [SBOX_AW-1:0] t_mem_off;
    logic               mem_we;
    logic               p_we;
    logic [PIDX_W-1:0]  p_widx;
    logic [31:0]        p_wdata;

    assign p_rd   = p_reg[cmd.p_idx];
    assign x_new  = (acc_reg + mem_q_reg) ^ y_reg;
    assign z_calc = p_rd ^ x_new;
    assign z_src  = cmd.chain ? z_calc : z_reg;

    always_comb
    begin
        unique case (cmd.kc_sel)
            2'd0:    kc_word = kc0_reg;
            2'd1:    kc_word = kc1_reg;
            default: kc_word = kc2_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.op)
            DP_CI_RD0: rd_addr = {SBOX_0, z_src[31:24]};
            DP_CI_RD1: rd_addr = {SBOX_1, z_reg[23:16]};
            DP_CI_RD2: rd_addr = {SBOX_2, z_reg[15:8]};
            DP_CI_RD3: rd_addr = {SBOX_3, z_reg[7:0]};
            default:   rd_addr = '0;
        endcase
    end

    // table write decode: low indexes hit the round keys, the rest the S-boxes
    always_comb
    begin
        t_we   = 1'b0;
        t_idx  = cmd.cnt;
        t_data = hi_reg;
        unique case (cmd.op)
            DP_LOAD_WORD:
            begin
                t_we   = 1'b1;
                t_idx  = tidx_reg;
                t_data = tval_reg;
            end
            DP_FILL_WH:
            begin
                t_we   = 1'b1;
                t_idx  = cmd.cnt;
                t_data = hi_reg;
            end
            DP_FILL_WL:
            begin
                t_we   = 1'b1;
                t_idx  = {cmd.cnt[TIDX_W-1:1], 1'b1};
                t_data = lo_reg;
            end
            default:
            begin
                t_we = 1'b0;
            end
        endcase
    end

    assign t_mem_off = SBOX_AW'(t_idx - TIDX_W'(P_WORDS));
    assign mem_we    = t_we && (t_idx >= TIDX_W'(P_WORDS))
                            && (t_idx < TIDX_W'(TABLE_WORDS));

    always_comb
    begin
        if (cmd.op == DP_KEY_XOR)
        begin
            p_we    = 1'b1;
            p_widx  = cmd.p_idx;
            p_wdata = p_rd ^ byte_rev(kc_word);
        end
        else
        begin
            p_we    = t_we && (t_idx < TIDX_W'(P_WORDS));
            p_widx  = t_idx[PIDX_W-1:0];
            p_wdata = t_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            p_reg[p_widx] <= p_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            sbox_mem[t_mem_off] <= t_data;
        mem_q_reg <= sbox_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                lo_reg   <= block_low;
                hi_reg   <= block_high;
                tidx_reg <= table_index;
                tval_reg <= table_value;
                kc0_reg  <= id_code;
                kc1_reg  <= id_code >> 1;
                kc2_reg  <= id_code << 1;
            end
            DP_CI_INIT:
            begin
                z_reg <= p_rd ^ hi_reg;
                y_reg <= lo_reg;
            end
            DP_CI_RD0:
            begin
                if (cmd.chain)
                begin
                    z_reg <= z_calc;
                    y_reg <= z_reg;
                end
            end
            DP_CI_RD1: acc_reg <= mem_q_reg;
            DP_CI_RD2: acc_reg <= acc_reg + mem_q_reg;
            DP_CI_RD3: acc_reg <= acc_reg ^ mem_q_reg;
            DP_CI_FIN:
            begin
                lo_reg <= x_new ^ (cmd.dec ? p_reg[1] : p_reg[ROUNDS]);
                hi_reg <= z_reg ^ (cmd.dec ? p_reg[0] : p_reg[ROUNDS + 1]);
            end
            DP_KC1_SET:
            begin
                lo_reg <= kc1_reg;
                hi_reg <= kc2_reg;
            end
            DP_KC1_WB:
            begin
                kc1_reg <= lo_reg;
                kc2_reg <= hi_reg;
            end
            DP_KC0_SET:
            begin
                lo_reg <= kc0_reg;
                hi_reg <= kc1_reg;
            end
            DP_KC0_WB:
            begin
                kc0_reg <= lo_reg;
                kc1_reg <= hi_reg;
            end
            DP_FILL_SET:
            begin
                lo_reg <= '0;
                hi_reg <= '0;
            end
            DP_KC_SHIFT:
            begin
                kc1_reg <= kc1_reg << 1;
                kc2_reg <= kc2_reg >> 1;
            end
            DP_RESULT:
            begin
                res_low_reg  <= cmd.zero_res ? 32'd0 : lo_reg;
                res_high_reg <= cmd.zero_res ? 32'd0 : hi_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_RESULT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign result_low      = res_low_reg;
    assign result_high     = res_high_reg;

endmodule

@@ hw/rtl/feistel_table_cipher_engine_top.sv @@
// 16-round Feistel block engine over a 1042-word table: 18 round keys
// followed by four 256-entry S-boxes.
// Input channel (in_valid/in_stall): one request per beat. req_type selects
// load table word, encrypt, decrypt or key schedule; unused fields ignored.
// Output channel (out_valid/out_stall): one result beat per request; the
// block words for encrypt/decrypt, zero for load and key schedule.
// Requests are taken one at a time; in_stall is high from acceptance until
// the result is handed to the output register.
// Encrypt/decrypt: 16 rounds, each reading the four S-boxes in turn through
// the single read port of the S-box memory.
// Key schedule, per keycode application: two keycode encryptions, a pass
// XORing the keycode into the 18 round keys, then 521 table re-encryptions
// plus writes; repeated level times. Level zero skips the schedule and goes
// straight to the result.
// A stalled result sits in the output register; a new request is still
// accepted, and the block holds its next result until that beat is taken.
// Reset clears control state only; table words read back as unknown until
// loaded.
module feistel_table_cipher_engine_top
    import fte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [10:0] table_index,
    input  logic [31:0] table_value,
    input  logic [31:0] block_low,
    input  logic [31:0] block_high,
    input  logic [31:0] id_code,
    input  logic [1:0]  sched_level,
    input  logic [1:0]  key_modulus,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_low,
    output logic [31:0] result_high
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fte_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .req_type    (req_type),
        .sched_level (sched_level),
        .key_modulus (key_modulus),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .status      (status)
    );

    fte_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .table_index (table_index),
        .table_value (table_value),
        .block_low   (block_low),
        .block_high  (block_high),
        .id_code     (id_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_low  (result_low),
        .result_high (result_high)
    );

endmodule
